// ===== sv/nsem_pkg.sv =====
// ----------------------------------------------------------------------------
// nsem_pkg
// Shared types, constants and helpers for the named counting semaphore table.
// ----------------------------------------------------------------------------
package nsem_pkg;

    localparam int SLOTS      = 16;
    localparam int NAME_BYTES = 8;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int SEL_W      = 5;
    localparam int RES_SLOT_W = 4;

    typedef enum logic [1:0] {
        OP_OPEN   = 2'd0,
        OP_WAIT   = 2'd1,
        OP_POST   = 2'd2,
        OP_UNLINK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_COUNT,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [63:0]        name_key;
        logic signed [15:0] initial_count;
        logic [SEL_W-1:0]   slot_select;
    } req_t;

    typedef struct packed {
        logic                  status;
        logic [RES_SLOT_W-1:0] slot_result;
        logic                  must_block;
        logic                  wake_waiter;
    } rsp_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
    localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;

    // keep bytes up to the first zero byte, within the name length
    function automatic logic [63:0] norm_name(input logic [63:0] key);
        logic [63:0] res;
        logic        alive;
        logic [7:0]  b;
        res   = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            b = key[8*i +: 8];
            if (i >= NAME_BYTES || b == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                res[8*i +: 8] = b;
            end
        end
        return res;
    endfunction

    // widen a slot index, then keep the low bits that the result field carries
    function automatic logic [RES_SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+RES_SLOT_W-1:0] wide;
        wide = {{RES_SLOT_W{1'b0}}, idx};
        return wide[RES_SLOT_W-1:0];
    endfunction

endpackage

// ===== sv/named_counting_semaphore_table.sv =====
// ----------------------------------------------------------------------------
// named_counting_semaphore_table
// Table of named counting semaphores with open, wait, post and unlink requests.
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall / req_data (req_t). a transaction is
//   taken when req_valid is high and req_stall is low; req_stall is high while
//   a request is being worked on, so one request is in the block at a time
//   response channel: rsp_valid / rsp_stall / rsp_data (rsp_t), one response
//   transaction per request, in request order
//   names and counts live in two synchronous RAMs (registered read); occupied
//   bits are flip-flops
//   steps, acceptance to rsp_valid:
//     wait / post: count read, update and write back, result
//     open / unlink: the name RAM is scanned one entry per cycle and the
//     scan stops at the first matching entry
//   a new request is taken only when the state machine is back in idle
//   the response sits in an output register, so a new request is accepted
//   while an earlier response is still stalled; a finished request waits in
//   its last state until that register is free
//   reset clears the occupied bits, the state machine and rsp_valid; RAM
//   contents are not cleared and are never used for a free slot
// ----------------------------------------------------------------------------
module named_counting_semaphore_table
    import nsem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,

    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    // control state
    state_t             state_reg, state_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               out_valid_reg, out_valid_next;

    // latched request and pending result
    op_t                op_reg, op_next;
    logic [63:0]        name_reg, name_next;
    logic signed [15:0] init_reg, init_next;
    logic [IDX_W-1:0]   sel_idx_reg, sel_idx_next;
    rsp_t               res_reg, res_next;
    rsp_t               out_reg, out_next;

    // memory ports
    logic               name_we;
    logic [IDX_W-1:0]   name_waddr;
    logic               name_re;
    logic [IDX_W-1:0]   name_raddr;
    logic [63:0]        name_rdata;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_waddr;
    logic [15:0]        cnt_wdata;
    logic               cnt_re;
    logic [IDX_W-1:0]   cnt_raddr;
    logic [15:0]        cnt_rdata;

    // request decode helpers
    logic                   accept;
    logic [SEL_W+IDX_W-1:0] sel_ext;
    logic [IDX_W-1:0]       sel_idx_in;
    logic                   sel_ok;
    logic                   scan_issue;
    logic                   chk_hit;
    logic                   chk_last;
    logic signed [15:0]     cur_cnt;
    logic signed [15:0]     new_cnt;

    // saturating step of the count: wait goes down, post goes up
    function automatic logic signed [15:0] new_cnt_calc(input op_t op,
                                                        input logic signed [15:0] c);
        logic signed [15:0] r;
        r = c;
        if (op == OP_WAIT)
        begin
            if (c != COUNT_MIN)
            begin
                r = c - 16'sd1;
            end
        end
        else
        begin
            if (c != COUNT_MAX)
            begin
                r = c + 16'sd1;
            end
        end
        return r;
    endfunction

    assign accept     = req_valid && !req_stall;
    assign req_stall  = (state_reg != ST_IDLE);
    assign sel_ext    = {{IDX_W{1'b0}}, req_data.slot_select};
    assign sel_idx_in = sel_ext[IDX_W-1:0];
    assign sel_ok     = (sel_ext < (SEL_W + IDX_W)'(SLOTS)) && used_reg[sel_idx_in];

    assign scan_issue = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(SLOTS));
    assign chk_hit    = chk_valid_reg && used_reg[chk_idx_reg] && (name_rdata == name_reg);
    assign chk_last   = chk_valid_reg && (chk_idx_reg == IDX_W'(SLOTS - 1));
    assign cur_cnt    = cnt_rdata;

    // name RAM read is driven by the scan counter
    assign name_re    = scan_issue;
    assign name_raddr = scan_cnt_reg[IDX_W-1:0];
    // count RAM read happens as a wait or post is accepted
    assign cnt_re     = accept && (req_data.op == OP_WAIT || req_data.op == OP_POST);
    assign cnt_raddr  = sel_idx_in;

    nsem_ram #(
        .WIDTH (64),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_reg),
        .re    (name_re),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    nsem_ram #(
        .WIDTH (16),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            scan_cnt_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            scan_cnt_reg   <= scan_cnt_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        op_reg        <= op_next;
        name_reg      <= name_next;
        init_reg      <= init_next;
        sel_idx_reg   <= sel_idx_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        name_next       = name_reg;
        init_next       = init_reg;
        sel_idx_next    = sel_idx_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        name_we         = 1'b0;
        name_waddr      = free_idx_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = sel_idx_reg;
        cnt_wdata       = new_cnt_calc(op_reg, cur_cnt);
        new_cnt         = cnt_wdata;

        // response register drains independently of the state machine
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req_data.op;
                    name_next       = norm_name(req_data.name_key);
                    init_next       = req_data.initial_count;
                    sel_idx_next    = sel_idx_in;
                    scan_cnt_next   = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    res_next        = '{status: STATUS_FAIL, slot_result: '0,
                                        must_block: 1'b0, wake_waiter: 1'b0};
                    unique case (req_data.op) inside
                        OP_OPEN, OP_UNLINK:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_WAIT, OP_POST:
                        begin
                            // free or out-of-range slot fails right away
                            state_next = sel_ok ? ST_COUNT : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue stage
                if (scan_issue)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
                // check stage, in the cycle after the read is issued
                if (chk_valid_reg && !used_reg[chk_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                if (chk_hit)
                begin
                    found_next     = 1'b1;
                    match_idx_next = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    state_next     = ST_APPLY;
                end
                else if (chk_last)
                begin
                    chk_valid_next = 1'b0;
                    state_next     = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                state_next = ST_DONE;
                if (op_reg == OP_OPEN)
                begin
                    if (found_reg)
                    begin
                        res_next.status      = STATUS_OK;
                        res_next.slot_result = slot_field(match_idx_reg);
                    end
                    else if (free_found_reg)
                    begin
                        // claim lowest free slot with the initial count
                        name_we                 = 1'b1;
                        cnt_we                  = 1'b1;
                        cnt_waddr               = free_idx_reg;
                        cnt_wdata               = init_reg;
                        used_next[free_idx_reg] = 1'b1;
                        res_next.status         = STATUS_OK;
                        res_next.slot_result    = slot_field(free_idx_reg);
                    end
                end
                else if (found_reg)
                begin
                    used_next[match_idx_reg] = 1'b0;
                    res_next.status          = STATUS_OK;
                end
            end

            ST_COUNT:
            begin
                // count read data is valid, write back the saturated update
                cnt_we          = 1'b1;
                res_next.status = STATUS_OK;
                if (op_reg == OP_WAIT)
                begin
                    res_next.must_block = new_cnt[15];
                end
                else
                begin
                    res_next.wake_waiter = new_cnt[15] || (new_cnt == 16'sd0);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ===== sv/nsem_ram.sv =====
// ----------------------------------------------------------------------------
// nsem_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/tb_named_counting_semaphore_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_named_counting_semaphore_table
// Self-checking bench for the named counting semaphore table: a directed
// opening pass over the corner cases, then about 1300 random requests drawn
// from a small pool of names, with random idle cycles on both channels and one
// long response hold-off. Every response transaction is compared against a
// table tracker that mirrors the slots in the bench.
// ----------------------------------------------------------------------------
module tb_named_counting_semaphore_table;
    import nsem_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int POOL_SIZE    = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 500;
    localparam int MAX_GAP      = 18;
    localparam int MAX_REPORTS  = 10;

    // ------------------------------------------------------------------------
    // table tracker: its own copy of the slots, predicts one reply per request
    // ------------------------------------------------------------------------
    class semaphore_table_tracker;
        bit                 slot_used  [SLOTS];
        logic [63:0]        slot_name  [SLOTS];
        logic signed [15:0] slot_count [SLOTS];
        rsp_t               pending_replies [$];
        int errors;
        int total, created, matched, full, blocked, woken, saturated, failed;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_used[k]  = 1'b0;
                slot_name[k]  = '0;
                slot_count[k] = '0;
            end
        endfunction

        // bytes up to the first zero byte, limited to the name length
        function logic [63:0] trim_name(logic [63:0] key);
            logic [63:0] res;
            bit          ended;
            res   = '0;
            ended = 1'b0;
            for (int b = 0; b < 8; b++)
            begin
                if (b >= NAME_BYTES || key[8*b +: 8] == 8'd0)
                    ended = 1'b1;
                if (!ended)
                    res[8*b +: 8] = key[8*b +: 8];
            end
            return res;
        endfunction

        function int find_slot(logic [63:0] nm);
            for (int k = 0; k < SLOTS; k++)
                if (slot_used[k] && slot_name[k] == nm)
                    return k;
            return -1;
        endfunction

        function void note_request(req_t r);
            rsp_t               e;
            logic [63:0]        nm;
            logic signed [15:0] c;
            int                 i;
            int                 s;
            e        = '0;
            e.status = STATUS_FAIL;
            nm       = trim_name(r.name_key);
            s        = int'(r.slot_select);
            total++;
            case (r.op) inside
                OP_OPEN:
                begin
                    i = find_slot(nm);
                    if (i >= 0)
                        matched++;
                    else
                    begin
                        for (int k = SLOTS - 1; k >= 0; k--)
                            if (!slot_used[k])
                                i = k;
                        if (i >= 0)
                        begin
                            slot_used[i]  = 1'b1;
                            slot_name[i]  = nm;
                            slot_count[i] = r.initial_count;
                            created++;
                        end
                        else
                            full++;
                    end
                    if (i >= 0)
                    begin
                        e.status      = STATUS_OK;
                        e.slot_result = RES_SLOT_W'(i);
                    end
                end
                OP_WAIT, OP_POST:
                begin
                    if (s < SLOTS && slot_used[s])
                    begin
                        c = slot_count[s];
                        if (r.op == OP_WAIT)
                        begin
                            if (c == COUNT_MIN)
                                saturated++;
                            else
                                c = c - 16'sd1;
                            e.must_block = (c < 0);
                        end
                        else
                        begin
                            if (c == COUNT_MAX)
                                saturated++;
                            else
                                c = c + 16'sd1;
                            e.wake_waiter = (c <= 0);
                        end
                        slot_count[s] = c;
                        e.status      = STATUS_OK;
                    end
                end
                default:
                begin
                    i = find_slot(nm);
                    if (i >= 0)
                    begin
                        slot_used[i] = 1'b0;
                        e.status     = STATUS_OK;
                    end
                end
            endcase
            if (e.status == STATUS_FAIL)
                failed++;
            if (e.must_block)
                blocked++;
            if (e.wake_waiter)
                woken++;
            pending_replies.push_back(e);
        endfunction

        function void check_reply(rsp_t got);
            rsp_t e;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected response: status %0d slot %0d block %0d wake %0d",
                             got.status, got.slot_result, got.must_block, got.wake_waiter);
                return;
            end
            e = pending_replies.pop_front();
            if (got.status !== e.status || got.slot_result !== e.slot_result ||
                got.must_block !== e.must_block || got.wake_waiter !== e.wake_waiter)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("mismatch at response %0d:", total - pending_replies.size());
                    $display("  expected status %0d slot %0d block %0d wake %0d",
                             e.status, e.slot_result, e.must_block, e.wake_waiter);
                    $display("  got      status %0d slot %0d block %0d wake %0d",
                             got.status, got.slot_result, got.must_block, got.wake_waiter);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    semaphore_table_tracker sb;
    logic [63:0] name_pool [POOL_SIZE];
    int sent;
    int received;
    int cycles;

    named_counting_semaphore_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, reckoned far above the slowest legal run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d replies outstanding",
                         cycles, sb.pending_replies.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // monitor: both channels are sampled at the rising edge only
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_data);
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_reply(rsp_data);
                received++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // name of len nonzero bytes, zero padded above
    function automatic logic [63:0] make_name(int len);
        logic [63:0] k;
        k = '0;
        for (int b = 0; b < len; b++)
            k[8*b +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // same name with junk behind the terminating zero byte
    function automatic logic [63:0] junk_tail(logic [63:0] nm);
        logic [63:0] k;
        int          len;
        len = 0;
        while (len < 8 && nm[8*len +: 8] != 8'd0)
            len++;
        k = nm;
        for (int b = len + 1; b < 8; b++)
            k[8*b +: 8] = 8'($urandom_range(0, 255));
        return k;
    endfunction

    function automatic logic [63:0] pool_name();
        logic [63:0] nm;
        nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) < 3)
            nm = junk_tail(nm);
        return nm;
    endfunction

    // counts near the saturation limits show up often
    function automatic logic signed [15:0] pick_count();
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom);
        case ($urandom_range(0, 6))
            0:       return COUNT_MIN;
            1:       return COUNT_MIN + 16'sd1;
            2:       return COUNT_MAX;
            3:       return COUNT_MAX - 16'sd1;
            4:       return 16'sd0;
            5:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // an occupied slot if there is one, searched from a random start
    function automatic int occupied_slot();
        int start;
        int idx;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            idx = (start + k) % SLOTS;
            if (sb.slot_used[idx])
                return idx;
        end
        return start;
    endfunction

    function automatic req_t build(op_t op, logic [63:0] key, logic signed [15:0] init,
                                   int sel);
        req_t r;
        r.op            = op;
        r.name_key      = key;
        r.initial_count = init;
        r.slot_select   = SEL_W'(sel);
        return r;
    endfunction

    // mostly well-formed traffic on pool names and live slots, some noise
    function automatic req_t random_request();
        req_t r;
        int   p;
        r.name_key      = {$urandom, $urandom};
        r.initial_count = 16'($urandom);
        r.slot_select   = SEL_W'($urandom);
        p = $urandom_range(0, 99);
        if (p < 38)
        begin
            r.op            = OP_OPEN;
            r.name_key      = pool_name();
            r.initial_count = pick_count();
        end
        else if (p < 86)
        begin
            r.op = (p < 62) ? OP_WAIT : OP_POST;
            if ($urandom_range(0, 99) < 75)
                r.slot_select = SEL_W'(occupied_slot());
        end
        else
        begin
            r.op = OP_UNLINK;
            if ($urandom_range(0, 4) != 0)
                r.name_key = pool_name();
        end
        return r;
    endfunction

    // one request transaction: random idle first, except in idle-free stretches
    task automatic send_request(req_t r);
        int gap;
        gap = ((sent / 128) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    // receiver: random stall before each response, one long hold-off midway
    initial
    begin
        int  gap;
        bit  held;
        rsp_stall = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ((received / 128) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (!held && received >= HOLD_AT)
            begin
                // long hold-off so the block backs up and stalls its input
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb        = new();
        sent      = 0;
        received  = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;

        // pool: empty name, all-ones key, a short name, then random lengths
        name_pool[0] = '0;
        name_pool[1] = '1;
        name_pool[2] = make_name(3);
        for (int k = 3; k < POOL_SIZE; k++)
            name_pool[k] = make_name($urandom_range(1, 8));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill the table, with the empty name and both count limits
        send_request(build(OP_OPEN, name_pool[0], COUNT_MIN, 0));
        send_request(build(OP_OPEN, name_pool[1], COUNT_MAX, 0));
        send_request(build(OP_OPEN, name_pool[2], 16'sd0, 0));
        send_request(build(OP_OPEN, name_pool[3], -16'sd1, 0));
        send_request(build(OP_OPEN, name_pool[4], 16'sd1, 0));
        for (int k = 5; k < SLOTS; k++)
            send_request(build(OP_OPEN, name_pool[k], pick_count(), 0));
        // a new name with every slot taken
        send_request(build(OP_OPEN, name_pool[SLOTS], 16'sd5, 0));
        // junk after the terminator still matches the short name
        send_request(build(OP_OPEN, junk_tail(name_pool[2]), 16'sd7, 0));
        // wait at the bottom and post at the top both saturate
        send_request(build(OP_WAIT, '0, '0, 0));
        send_request(build(OP_POST, '0, '0, 1));
        send_request(build(OP_POST, '0, '0, 0));
        // slot out of range
        send_request(build(OP_WAIT, '1, '1, (1 << SEL_W) - 1));
        // unlink, then a post on the freed slot and a second unlink both fail
        send_request(build(OP_UNLINK, name_pool[5], '0, 0));
        send_request(build(OP_POST, '0, '0, 5));
        send_request(build(OP_UNLINK, name_pool[5], '0, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_request(random_request());
        @(negedge clk);
        req_valid <= 1'b0;

        // drain, then watch a little longer for stray responses
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d opens created, %0d opened by name, %0d on a full table",
                 sb.total, sb.created, sb.matched, sb.full);
        $display("%0d blocking waits, %0d wakes, %0d saturated, %0d failed, %0d errors",
                 sb.blocked, sb.woken, sb.saturated, sb.failed, sb.errors);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/nsem_pkg.sv
sv/nsem_ram.sv
sv/named_counting_semaphore_table.sv
test/tb_named_counting_semaphore_table.sv
